// ===== rtl/binary_gcd_lcm_core_macros.svh =====
// ----------------------------------------------------------------------------
// binary_gcd_lcm_core_macros.svh
// assertion shorthands shared by the binary gcd / lcm core
// ----------------------------------------------------------------------------
`ifndef BINARY_GCD_LCM_CORE_MACROS_SVH
`define BINARY_GCD_LCM_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BGL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BGL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bgl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_pkg
// microcode format, program and shared types of the binary gcd / lcm core
// ----------------------------------------------------------------------------
package bgl_pkg;

  localparam int unsigned GCD_BITS = 32;
  localparam int unsigned LCM_BITS = 64;

  typedef logic [3:0] step_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ZERO_RES,
    OP_SHIFT_BOTH,
    OP_SHIFT_X,
    OP_SHIFT_Y,
    OP_SWAP_SUB,
    OP_GCD_FIN,
    OP_DIV_STEP,
    OP_MUL,
    OP_PUBLISH
  } op_e;

  // branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_ANY_ZERO,
    C_BOTH_EVEN,
    C_X_EVEN,
    C_Y_EVEN,
    C_Y_NONZERO,
    C_DIV_BUSY,
    C_OUT_FREE
  } cond_e;

  // op runs and tgt_t is taken when cond holds, else tgt_f
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_e   op;
    logic  in_ready;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic any_zero;
    logic both_even;
    logic x_even;
    logic y_even;
    logic y_nonzero;
    logic div_busy;
    logic out_free;
  } stat_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_ZCHK  = 4'd1;
  localparam step_t S_STRIP = 4'd2;
  localparam step_t S_XODD  = 4'd3;
  localparam step_t S_YODD  = 4'd4;
  localparam step_t S_SUB   = 4'd5;
  localparam step_t S_YNZ   = 4'd6;
  localparam step_t S_GFIN  = 4'd7;
  localparam step_t S_DIV   = 4'd8;
  localparam step_t S_MUL   = 4'd9;
  localparam step_t S_OUT   = 4'd10;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      S_IDLE:  w = '{OP_LOAD,       C_IN_VALID,  S_ZCHK,  S_IDLE};
      S_ZCHK:  w = '{OP_ZERO_RES,   C_ANY_ZERO,  S_OUT,   S_STRIP};
      S_STRIP: w = '{OP_SHIFT_BOTH, C_BOTH_EVEN, S_STRIP, S_XODD};
      S_XODD:  w = '{OP_SHIFT_X,    C_X_EVEN,    S_XODD,  S_YODD};
      S_YODD:  w = '{OP_SHIFT_Y,    C_Y_EVEN,    S_YODD,  S_SUB};
      S_SUB:   w = '{OP_SWAP_SUB,   C_ALWAYS,    S_YNZ,   S_YNZ};
      S_YNZ:   w = '{OP_NOP,        C_Y_NONZERO, S_YODD,  S_GFIN};
      S_GFIN:  w = '{OP_GCD_FIN,    C_ALWAYS,    S_DIV,   S_DIV};
      S_DIV:   w = '{OP_DIV_STEP,   C_DIV_BUSY,  S_DIV,   S_MUL};
      S_MUL:   w = '{OP_MUL,        C_ALWAYS,    S_OUT,   S_OUT};
      S_OUT:   w = '{OP_PUBLISH,    C_OUT_FREE,  S_IDLE,  S_OUT};
      default: w = '{OP_NOP,        C_ALWAYS,    S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/binary_gcd_lcm_core.sv =====
`timescale 1ns / 1ps
// an operand of 0 skips the gcd loop, the divide and the multiply and goes
// straight to the output step
// one word in flight: the next word can be taken the cycle after the result is
// published; the subtract loop and the W-step restoring divider dominate the run time
// reset: asynchronous, active low; returns the step counter to idle and drops
// the output valid, working registers keep no reset
// ----------------------------------------------------------------------------
// binary_gcd_lcm_core
// gcd by stein's binary method and lcm as (a / gcd) * b, microcoded
// ----------------------------------------------------------------------------
`include "binary_gcd_lcm_core_macros.svh"

module binary_gcd_lcm_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] gcd_value, [95:32] lcm_value
  output logic        m_axis_tuser    // [0] both_zero
);

  localparam int unsigned W = OPERAND_WIDTH;

  bgl_pkg::ctrl_t ctrl;
  bgl_pkg::stat_t stat;

  logic [W-1:0]   opa, opb;
  logic [W-1:0]   gcd_w;
  logic [2*W-1:0] lcm_w;
  logic           bz_w;
  logic           s_fire;

  // only the low W bits of each operand count
  assign opa = s_axis_tdata[W-1:0];
  assign opb = s_axis_tdata[32+W-1:32];

  assign s_axis_tready = ctrl.in_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // step counter and control rom
  bgl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // arithmetic and the output word register
  bgl_dp #(
    .W (W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .opa_i       (opa),
    .opb_i       (opb),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .gcd_o       (gcd_w),
    .lcm_o       (lcm_w),
    .both_zero_o (bz_w)
  );

  // zero-extend narrow results to the fixed field widths
  assign m_axis_tdata = {bgl_pkg::LCM_BITS'(lcm_w), bgl_pkg::GCD_BITS'(gcd_w)};
  assign m_axis_tuser = bz_w;

  `BGL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_fire, !s_axis_tready, "accepted a word while busy")
  `BGL_ASSERT_IMPLY(a_zero_word_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "both_zero word carries nonzero data")
  `BGL_ASSERT_IMPLY(a_gcd_nonzero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:0] != '0, "gcd is zero without both_zero")

endmodule

// ===== rtl/bgl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_seq
// step counter and microcode rom with two-way conditional branch
// ----------------------------------------------------------------------------
module bgl_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  bgl_pkg::stat_t stat_i,
  output bgl_pkg::ctrl_t ctrl_o
);

  bgl_pkg::step_t  pc_q, pc_d;
  bgl_pkg::ucode_t uw;
  logic            cond_true;

  assign uw = bgl_pkg::ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      bgl_pkg::C_ALWAYS:    cond_true = 1'b1;
      bgl_pkg::C_IN_VALID:  cond_true = in_valid_i;
      bgl_pkg::C_ANY_ZERO:  cond_true = stat_i.any_zero;
      bgl_pkg::C_BOTH_EVEN: cond_true = stat_i.both_even;
      bgl_pkg::C_X_EVEN:    cond_true = stat_i.x_even;
      bgl_pkg::C_Y_EVEN:    cond_true = stat_i.y_even;
      bgl_pkg::C_Y_NONZERO: cond_true = stat_i.y_nonzero;
      bgl_pkg::C_DIV_BUSY:  cond_true = stat_i.div_busy;
      bgl_pkg::C_OUT_FREE:  cond_true = stat_i.out_free;
      default:              cond_true = 1'b0;
    endcase
  end

  assign pc_d = cond_true ? uw.tgt_t : uw.tgt_f;

  always_comb begin
    ctrl_o.op       = cond_true ? uw.op : bgl_pkg::OP_NOP;
    ctrl_o.in_ready = (pc_q == bgl_pkg::S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bgl_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/bgl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgl_dp
// gcd / divide / multiply datapath with result register
// ----------------------------------------------------------------------------
module bgl_dp #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bgl_pkg::ctrl_t ctrl_i,
  input  logic [W-1:0]   opa_i,
  input  logic [W-1:0]   opb_i,
  input  logic           out_ready_i,
  output bgl_pkg::stat_t stat_o,
  output logic           out_valid_o,
  output logic [W-1:0]   gcd_o,
  output logic [2*W-1:0] lcm_o,
  output logic           both_zero_o
);

  localparam int unsigned KW = $clog2(W + 1);

  logic [W-1:0]   x_q, y_q, sa_q, sb_q, g_q, rem_q, quo_q;
  logic [KW-1:0]  k_q, cnt_q;
  logic [2*W-1:0] prod_q;
  logic           bz_q, vld_q;
  logic [W-1:0]   res_g_q;
  logic [2*W-1:0] res_l_q;
  logic           res_bz_q;

  logic [W:0]     div_sh, div_diff;

  assign div_sh   = {rem_q, quo_q[W-1]};
  assign div_diff = div_sh - {1'b0, g_q};

  always_comb begin
    stat_o.any_zero  = (x_q == '0) || (y_q == '0);
    stat_o.both_even = !x_q[0] && !y_q[0];
    stat_o.x_even    = !x_q[0];
    stat_o.y_even    = !y_q[0];
    stat_o.y_nonzero = (y_q != '0);
    stat_o.div_busy  = (cnt_q != KW'(W));
    stat_o.out_free  = !vld_q || out_ready_i;
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      bgl_pkg::OP_LOAD: begin
        x_q  <= opa_i;
        y_q  <= opb_i;
        sa_q <= opa_i;
        sb_q <= opb_i;
        k_q  <= '0;
      end
      bgl_pkg::OP_ZERO_RES: begin
        g_q    <= x_q | y_q;
        prod_q <= '0;
        bz_q   <= ((x_q | y_q) == '0);
      end
      bgl_pkg::OP_SHIFT_BOTH: begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end
      bgl_pkg::OP_SHIFT_X: x_q <= x_q >> 1;
      bgl_pkg::OP_SHIFT_Y: y_q <= y_q >> 1;
      bgl_pkg::OP_SWAP_SUB: begin
        if (x_q > y_q) begin
          x_q <= y_q;
          y_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
      end
      bgl_pkg::OP_GCD_FIN: begin
        g_q   <= x_q << k_q;
        rem_q <= '0;
        quo_q <= sa_q;
        cnt_q <= '0;
        bz_q  <= 1'b0;
      end
      bgl_pkg::OP_DIV_STEP: begin
        if (!div_diff[W]) begin
          rem_q <= div_diff[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= div_sh[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      bgl_pkg::OP_MUL: prod_q <= (2*W)'(quo_q) * (2*W)'(sb_q);
      bgl_pkg::OP_PUBLISH: begin
        res_g_q  <= g_q;
        res_l_q  <= prod_q;
        res_bz_q <= bz_q;
      end
      default: ;
    endcase
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.op == bgl_pkg::OP_PUBLISH) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  assign out_valid_o = vld_q;
  assign gcd_o       = res_g_q;
  assign lcm_o       = res_l_q;
  assign both_zero_o = res_bz_q;

endmodule

// ===== test/binary_gcd_lcm_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_gcd_lcm_core_tb
// self-checking bench for the gcd / lcm core: operand pairs go in on the
// slave stream, and every result word is checked field by field against a
// euclid-based prediction held in order of acceptance
// ----------------------------------------------------------------------------
module binary_gcd_lcm_core_tb;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned RANDOM_PAIRS  = 880;
  localparam int unsigned TAIL_PAIRS    = 100;     // no idling on either side here
  localparam int unsigned DRAIN_CYCLES  = 6 * OPERAND_WIDTH + 40;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    bit          drain_first;   // sender holds off until nothing is outstanding
  } operand_pair_t;

  typedef struct {
    logic [bgl_pkg::GCD_BITS-1:0] gcd;
    logic [bgl_pkg::LCM_BITS-1:0] lcm;
    logic                         both_zero;
  } gcd_lcm_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic        m_tuser;

  operand_pair_t pending_pairs[$];
  gcd_lcm_t      expected_results[$];
  int unsigned   src_gap;
  int unsigned   sink_stall;
  int unsigned   error_cnt;
  int unsigned   cycle_cnt;

  binary_gcd_lcm_core #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  // gcd by euclid's remainder loop, lcm as (a / gcd) * b in 64 bits
  function automatic gcd_lcm_t predict_gcd_lcm(logic [31:0] a_in, logic [31:0] b_in);
    logic [31:0] mask;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] r;
    gcd_lcm_t    res;
    mask = 32'hFFFF_FFFF >> (32 - OPERAND_WIDTH);
    x    = a_in & mask;
    y    = b_in & mask;
    res  = '{gcd: '0, lcm: '0, both_zero: 1'b0};
    if (x == 0 && y == 0) begin
      res.both_zero = 1'b1;
      return res;
    end
    res.lcm = 64'(a_in & mask);
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res.gcd = x;
    res.lcm = (res.lcm / 64'(x)) * 64'(b_in & mask);
    return res;
  endfunction

  function automatic void add_pair(logic [31:0] a, logic [31:0] b, bit drain = 1'b0);
    pending_pairs.insert(pending_pairs.size(), '{a: a, b: b, drain_first: drain});
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sender: presents queued pairs, predicts on acceptance, idles in short bursts
  always @(posedge clk_i or negedge rst_ni) begin : src_drive
    logic          nxt_valid;
    logic [63:0]   nxt_data;
    operand_pair_t nxt_pair;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      nxt_valid = s_tvalid;
      nxt_data  = s_tdata;
      if (s_tvalid && s_tready) begin
        expected_results.insert(expected_results.size(),
                                predict_gcd_lcm(s_tdata[31:0], s_tdata[63:32]));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap != 0) begin
          src_gap--;
        end else if (pending_pairs.size() != 0) begin
          if (pending_pairs[0].drain_first && expected_results.size() != 0) begin
            // hold off until the core has handed back every word
          end else if (pending_pairs.size() > TAIL_PAIRS && $urandom_range(0, 4) == 0) begin
            src_gap = $urandom_range(0, 2);
          end else begin
            nxt_pair  = pending_pairs.pop_front();
            nxt_valid = 1'b1;
            nxt_data  = {nxt_pair.b, nxt_pair.a};
          end
        end
      end
      s_tvalid <= nxt_valid;
      s_tdata  <= nxt_data;
    end
  end

  // receiver: checks each accepted word, stalls in short bursts
  always @(posedge clk_i or negedge rst_ni) begin : sink_check
    gcd_lcm_t want;
    logic     nxt_ready;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("unexpected word: gcd %h lcm %h both_zero %b",
                     m_tdata[31:0], m_tdata[95:32], m_tuser);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[31:0] !== want.gcd || m_tdata[95:32] !== want.lcm ||
              m_tuser !== want.both_zero) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display("mismatch: exp gcd %h lcm %h both_zero %b, got gcd %h lcm %h both_zero %b",
                       want.gcd, want.lcm, want.both_zero,
                       m_tdata[31:0], m_tdata[95:32], m_tuser);
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
        nxt_ready = 1'b0;
      end else if (pending_pairs.size() > TAIL_PAIRS && $urandom_range(0, 4) == 0) begin
        sink_stall = $urandom_range(0, 2);
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      m_tready <= nxt_ready;
    end
  end

  initial begin : stimulus
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] g;

    // directed corners: zeros, extremes, powers of two, coprime maxima
    add_pair(32'h0, 32'h0);
    add_pair(32'h0, 32'h5);
    add_pair(32'h7, 32'h0);
    add_pair(32'h0, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'h0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pair(32'h1, 32'h1);
    add_pair(32'h1, 32'hFFFF_FFFF);
    add_pair(32'hFFFF_FFFF, 32'h1);
    add_pair(32'h8000_0000, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h1);
    add_pair(32'h4000_0000, 32'hC000_0000);
    add_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);   // lcm close to 2^64
    add_pair(32'hFFFF_FFFB, 32'hFFFF_FFFF);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);
    add_pair(32'd12, 32'd18);
    add_pair(32'd17, 32'd17);
    add_pair(32'd6, 32'd35);
    add_pair(32'd1024, 32'd96);
    add_pair(32'h0, 32'h8000_0000);
    add_pair(32'h0000_0002, 32'h0000_0000, 1'b1);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = $urandom;
          b = $urandom;
        end
        3, 4: begin
          // large shared factor
          g = $urandom_range(1, 65535) << $urandom_range(0, 8);
          a = g * ($urandom >> $urandom_range(16, 31));
          b = g * ($urandom >> $urandom_range(16, 31));
        end
        5: begin
          // many shared factors of two
          a = $urandom << $urandom_range(0, 31);
          b = $urandom << $urandom_range(0, 31);
        end
        6: begin
          a = $urandom;
          b = 32'h0;
          if ($urandom_range(0, 7) == 0) a = 32'h0;
          if ($urandom_range(0, 1) == 0) begin
            b = a;
            a = 32'h0;
          end
        end
        7: begin
          a = $urandom >> $urandom_range(0, 31);
          b = a * $urandom_range(1, 9);
        end
        8: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        default: begin
          a = ~32'($urandom_range(0, 15));
          b = ~32'($urandom_range(0, 15));
        end
      endcase
      add_pair(a, b, i == 300 || i == 600);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_pairs.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
